// ----- sv/sst_pkg.sv -----
`default_nettype none

package sst_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int TOK_W = 16;
	localparam int MAX_RES = 3;

	typedef enum logic [3:0] {
		KIND_HASH   = 4'd0,
		KIND_DOT    = 4'd1,
		KIND_LBRACE = 4'd2,
		KIND_COLON  = 4'd3,
		KIND_SEMI   = 4'd4,
		KIND_RBRACE = 4'd5,
		KIND_IDENT  = 4'd6,
		KIND_KEY    = 4'd7,
		KIND_VALUE  = 4'd8,
		KIND_UNIT   = 4'd9,
		KIND_STOP   = 4'd10
	} kind_t;

	typedef enum logic [1:0] {
		CTX_NONE  = 2'd0,
		CTX_KEY   = 2'd1,
		CTX_VALUE = 2'd2,
		CTX_UNIT  = 2'd3
	} ctx_t;

	typedef struct packed {
		kind_t              kind;
		logic [TOK_W-1:0]   start;
		logic [TOK_W-1:0]   length;
	} tok_t;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_digit(c) || (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) ||
			c == CH_DASH || c == CH_UNDER;
	endfunction

	// space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c inside {[8'h09:8'h0D]});
	endfunction

endpackage

`default_nettype wire

// ----- sv/sst_in_if.sv -----
`default_nettype none

interface sst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_source;

	modport source (output valid, output source_byte, output end_of_source, input ready);
	modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

`default_nettype wire

// ----- sv/sst_out_if.sv -----
`default_nettype none

interface sst_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_start, output token_length,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start, input token_length,
		input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/style_sheet_tokenizer.sv -----
`default_nettype none

// Style-sheet tokenizer. Takes one source byte per word on the source channel and
// reports tokens (kind, start offset, length) on the tokens channel; an end-of-source
// word flushes the open token and any pending empty key/value/unit, emits a stop and
// re-arms the block. Each byte is classified combinationally and the context is updated
// when it is taken; its tokens appear on the tokens channel the cycle after the byte is
// taken. A byte is taken every cycle as long as it yields at most one token that is
// taken right away; a byte yielding more tokens keeps the source waiting until the last
// of them is being taken, while the three-entry result register drains one token per
// cycle while the sink is ready. Token text is not delivered: the consumer slices it
// out of the source using start and length.
module style_sheet_tokenizer
	import sst_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sst_in_if.sink     source,
	sst_out_if.source  tokens
);

	localparam int EXT_W = (OFFSET_BITS > TOK_W) ? OFFSET_BITS : TOK_W;

	// tokenizer state
	ctx_t                   ctx_q;
	logic                   open_q;
	kind_t                  open_kind_q;
	logic [OFFSET_BITS-1:0] open_start_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic                   halted_q;

	// result register
	tok_t       res_q [MAX_RES];
	logic [1:0] cnt_q;

	logic acc, pop;

	logic [EXT_W-1:0] off_ext, start_ext, len_ext;
	logic [TOK_W-1:0] off16, start16, len16;

	assign off_ext   = EXT_W'(off_q);
	assign start_ext = EXT_W'(open_start_q);
	assign len_ext   = EXT_W'(off_q - open_start_q);
	assign off16     = off_ext[TOK_W-1:0];
	assign start16   = start_ext[TOK_W-1:0];
	assign len16     = len_ext[TOK_W-1:0];

	// fresh-byte classification
	tok_t       f [MAX_RES];
	logic [1:0] fn;
	ctx_t       f_ctx;
	logic       f_open;
	kind_t      f_kind;
	logic       f_halt;

	always_comb begin
		logic [7:0] c;
		logic       pn;
		kind_t      pk;
		kind_t      ek;
		c = source.source_byte;
		for (int i = 0; i < MAX_RES; i++) begin
			f[i] = '0;
		end
		fn = 2'd0;
		f_ctx = ctx_q;
		f_open = 1'b0;
		f_kind = KIND_IDENT;
		f_halt = 1'b0;
		pn = 1'b1;
		pk = KIND_HASH;
		case (c)
			CH_HASH:   pk = KIND_HASH;
			CH_DOT:    pk = KIND_DOT;
			CH_LBRACE: pk = KIND_LBRACE;
			CH_COLON:  pk = KIND_COLON;
			CH_SEMI:   pk = KIND_SEMI;
			CH_RBRACE: pk = KIND_RBRACE;
			default:   pn = 1'b0;
		endcase
		ek = (ctx_q == CTX_KEY) ? KIND_KEY : KIND_UNIT;

		if (is_space(c)) begin
			// skipped
		end else if (pn) begin
			f[0] = '{kind: pk, start: off16, length: TOK_W'(1)};
			fn = 2'd1;
			case (pk)
				KIND_LBRACE, KIND_SEMI: f_ctx = CTX_KEY;
				KIND_COLON:             f_ctx = CTX_VALUE;
				KIND_RBRACE:            f_ctx = CTX_NONE;
				default:                f_ctx = ctx_q;
			endcase
		end else begin
			case (ctx_q)
				CTX_VALUE: begin
					if (is_digit(c)) begin
						f_open = 1'b1;
						f_kind = KIND_VALUE;
						f_ctx = CTX_UNIT;
					end else if (is_ident(c)) begin
						f[0] = '{kind: KIND_VALUE, start: off16, length: '0};
						fn = 2'd1;
						f_open = 1'b1;
						f_kind = KIND_UNIT;
						f_ctx = CTX_NONE;
					end else begin
						f[0] = '{kind: KIND_VALUE, start: off16, length: '0};
						f[1] = '{kind: KIND_UNIT, start: off16, length: '0};
						f[2] = '{kind: KIND_STOP, start: off16, length: '0};
						fn = 2'd3;
						f_halt = 1'b1;
						f_ctx = CTX_NONE;
					end
				end
				CTX_KEY, CTX_UNIT: begin
					f_ctx = CTX_NONE;
					if (is_ident(c)) begin
						f_open = 1'b1;
						f_kind = ek;
					end else begin
						f[0] = '{kind: ek, start: off16, length: '0};
						f[1] = '{kind: KIND_STOP, start: off16, length: '0};
						fn = 2'd2;
						f_halt = 1'b1;
					end
				end
				default: begin
					if (is_ident(c)) begin
						f_open = 1'b1;
						f_kind = KIND_IDENT;
					end else begin
						f[0] = '{kind: KIND_STOP, start: off16, length: '0};
						fn = 2'd1;
						f_halt = 1'b1;
					end
				end
			endcase
		end
	end

	// next state and results for the word on the source channel
	tok_t                   nres [MAX_RES];
	logic [1:0]             ncnt;
	ctx_t                   n_ctx;
	logic                   n_open;
	kind_t                  n_kind;
	logic [OFFSET_BITS-1:0] n_start;
	logic [OFFSET_BITS-1:0] n_off;
	logic                   n_halted;

	always_comb begin
		tok_t       e [MAX_RES+1];
		logic [2:0] ec;
		tok_t       cl;
		logic       cont;
		logic [2:0] sum;
		for (int i = 0; i < MAX_RES + 1; i++) begin
			e[i] = '0;
		end
		for (int i = 0; i < MAX_RES; i++) begin
			nres[i] = '0;
		end
		ec = 3'd0;
		sum = 3'd0;
		ncnt = 2'd0;
		n_ctx = ctx_q;
		n_open = open_q;
		n_kind = open_kind_q;
		n_start = open_start_q;
		n_off = off_q;
		n_halted = halted_q;
		cl = '{kind: open_kind_q, start: start16, length: len16};
		cont = (open_kind_q == KIND_VALUE) ? is_digit(source.source_byte)
			: is_ident(source.source_byte);

		if (source.end_of_source) begin
			if (!halted_q) begin
				if (open_q) begin
					e[ec[1:0]] = cl;
					ec = ec + 3'd1;
				end
				case (ctx_q)
					CTX_VALUE: begin
						e[ec[1:0]] = '{kind: KIND_VALUE, start: off16, length: '0};
						ec = ec + 3'd1;
						e[ec[1:0]] = '{kind: KIND_UNIT, start: off16, length: '0};
						ec = ec + 3'd1;
					end
					CTX_KEY: begin
						e[ec[1:0]] = '{kind: KIND_KEY, start: off16, length: '0};
						ec = ec + 3'd1;
					end
					CTX_UNIT: begin
						e[ec[1:0]] = '{kind: KIND_UNIT, start: off16, length: '0};
						ec = ec + 3'd1;
					end
					default: ;
				endcase
			end
			e[ec[1:0]] = '{kind: KIND_STOP, start: off16, length: '0};
			ec = ec + 3'd1;
			for (int i = 0; i < MAX_RES; i++) begin
				nres[i] = e[i];
			end
			ncnt = (ec > 3'd3) ? 2'd3 : ec[1:0];
			n_ctx = CTX_NONE;
			n_open = 1'b0;
			n_kind = KIND_HASH;
			n_start = '0;
			n_off = '0;
			n_halted = 1'b0;
		end else if (!halted_q) begin
			if (open_q && cont) begin
				// token keeps growing
			end else begin
				if (open_q) begin
					nres[0] = cl;
					nres[1] = f[0];
					nres[2] = f[1];
					sum = {1'b0, fn} + 3'd1;
					ncnt = (sum > 3'd3) ? 2'd3 : sum[1:0];
				end else begin
					for (int i = 0; i < MAX_RES; i++) begin
						nres[i] = f[i];
					end
					ncnt = fn;
				end
				n_ctx = f_ctx;
				n_open = f_open;
				if (f_open) begin
					n_kind = f_kind;
					n_start = off_q;
				end
				n_halted = f_halt;
			end
			n_off = (off_q == '1) ? off_q : off_q + 1'b1;
		end
	end

	assign pop = tokens.valid && tokens.ready;
	assign acc = source.valid && source.ready;
	assign source.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && tokens.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_NONE;
			open_q <= 1'b0;
			open_kind_q <= KIND_HASH;
			open_start_q <= '0;
			off_q <= '0;
			halted_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				ctx_q <= n_ctx;
				open_q <= n_open;
				open_kind_q <= n_kind;
				open_start_q <= n_start;
				off_q <= n_off;
				halted_q <= n_halted;
				cnt_q <= ncnt;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= nres[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	assign tokens.valid        = (cnt_q != 2'd0);
	assign tokens.token_kind   = res_q[0].kind;
	assign tokens.token_start  = res_q[0].start;
	assign tokens.token_length = res_q[0].length;
	assign tokens.last_of_run  = (cnt_q == 2'd1);

	// a value token always leaves a unit pending; key/unit/ident leave none
	a_open_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (ctx_q == CTX_NONE || ctx_q == CTX_UNIT))
		else $error("token open with key or value pending");

	a_open_start: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (open_start_q <= off_q))
		else $error("open token starts beyond current offset");

	a_eos_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && source.end_of_source) |=> (tokens.valid && off_q == '0 && !open_q))
		else $error("end of source did not flush and re-arm");

	a_halt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && halted_q && !source.end_of_source) |=> ($stable(off_q) && cnt_q == 2'd0))
		else $error("halted tokenizer advanced or produced tokens");

endmodule

`default_nettype wire

// ----- sim/style_sheet_tokenizer_tb.sv -----
`timescale 1ns / 100ps

module style_sheet_tokenizer_tb
	import sst_pkg::*;
();

	localparam int OFF_W = OFFSET_BITS_DEF;
	localparam int CYCLE_LIMIT = 50_000;
	localparam int RANDOM_WORDS = 360;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int DIRECTED_N = 25;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef struct packed {
		logic [7:0]       b;
		logic             eos;
		logic             typed;
		kind_t            kind;
		logic [TOK_W-1:0] start;
		logic [TOK_W-1:0] length;
	} src_word_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} tok_exp_t;

	typedef enum {RX_FREE, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

	logic clk;
	logic arst_n;
	sst_in_if  byte_ch();
	sst_out_if tok_ch();

	style_sheet_tokenizer #(.OFFSET_BITS(OFF_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.source(byte_ch),
		.tokens(tok_ch)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// directed words; expected token typed in only where it is obvious
	src_word_t directed_tbl [DIRECTED_N] = '{
		'{CH_HASH,   1'b0, 1'b1, KIND_HASH,   16'd0,  16'd1},
		'{CH_DOT,    1'b0, 1'b1, KIND_DOT,    16'd1,  16'd1},
		'{8'h61,     1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_LBRACE, 1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_UNDER,  1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_COLON,  1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{8'h39,     1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_DASH,   1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_SEMI,   1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_COLON,  1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{8'h78,     1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_TAB,    1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_COLON,  1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{8'h00,     1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{8'h5A,     1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{8'h00,     1'b1, 1'b1, KIND_STOP,   16'd14, 16'd0},
		'{CH_LBRACE, 1'b0, 1'b1, KIND_LBRACE, 16'd0,  16'd1},
		'{8'h35,     1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_CR,     1'b1, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_COLON,  1'b0, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{8'hFF,     1'b1, 1'b0, KIND_STOP,   16'd0,  16'd0},
		'{CH_RBRACE, 1'b0, 1'b1, KIND_RBRACE, 16'd0,  16'd1},
		'{8'hFF,     1'b0, 1'b1, KIND_STOP,   16'd1,  16'd0},
		'{8'h20,     1'b1, 1'b1, KIND_STOP,   16'd2,  16'd0},
		'{8'hA5,     1'b1, 1'b1, KIND_STOP,   16'd0,  16'd0}
	};

	src_word_t src_words[$];
	tok_exp_t  pending_toks[$];
	tok_t      run_toks[$];

	// tokenizer state mirror
	ctx_t             p_ctx;
	logic             p_open;
	kind_t            p_kind;
	logic [OFF_W-1:0] p_start;
	logic [OFF_W-1:0] p_off;
	logic             p_halted;

	logic gen_halted = 1'b0;
	int   n_live = 0;
	int   hold_at = -1;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   n_errors = 0;
	int   n_taken = 0;
	int   n_tokens = 0;
	int   n_stops = 0;

	function automatic logic digit_b(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic word_b(logic [7:0] c);
		return digit_b(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			c == CH_DASH || c == CH_UNDER;
	endfunction

	function automatic logic blank_b(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic punct_b(logic [7:0] c);
		return c == CH_HASH || c == CH_DOT || c == CH_LBRACE || c == CH_COLON ||
			c == CH_SEMI || c == CH_RBRACE;
	endfunction

	function automatic void clear_tokenizer();
		p_ctx = CTX_NONE;
		p_open = 1'b0;
		p_kind = KIND_HASH;
		p_start = '0;
		p_off = '0;
		p_halted = 1'b0;
	endfunction

	function automatic void put_tok(kind_t k, logic [OFF_W-1:0] s, logic [OFF_W-1:0] n);
		tok_t t;
		if (run_toks.size() < MAX_RES) begin
			t.kind = k;
			t.start = TOK_W'(s);
			t.length = TOK_W'(n);
			run_toks.insert(run_toks.size(), t);
		end
	endfunction

	function automatic void close_tok();
		if (p_open) begin
			put_tok(p_kind, p_start, (p_off >= p_start) ? p_off - p_start : '0);
			p_open = 1'b0;
		end
	endfunction

	function automatic void open_tok(kind_t k);
		p_open = 1'b1;
		p_kind = k;
		p_start = p_off;
	endfunction

	// byte with no token open; an empty expected token sends the byte round again
	function automatic void fresh_byte(logic [7:0] c);
		logic again;
		kind_t k;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			if (punct_b(c)) begin
				case (c)
					CH_HASH: put_tok(KIND_HASH, p_off, OFF_W'(1));
					CH_DOT: put_tok(KIND_DOT, p_off, OFF_W'(1));
					CH_LBRACE: begin
						put_tok(KIND_LBRACE, p_off, OFF_W'(1));
						p_ctx = CTX_KEY;
					end
					CH_COLON: begin
						put_tok(KIND_COLON, p_off, OFF_W'(1));
						p_ctx = CTX_VALUE;
					end
					CH_SEMI: begin
						put_tok(KIND_SEMI, p_off, OFF_W'(1));
						p_ctx = CTX_KEY;
					end
					default: begin
						put_tok(KIND_RBRACE, p_off, OFF_W'(1));
						p_ctx = CTX_NONE;
					end
				endcase
			end else if (blank_b(c)) begin
				// skipped, context untouched
			end else if (p_ctx == CTX_VALUE) begin
				p_ctx = CTX_UNIT;
				if (digit_b(c)) begin
					open_tok(KIND_VALUE);
				end else begin
					put_tok(KIND_VALUE, p_off, '0);
					again = 1'b1;
				end
			end else if (p_ctx != CTX_NONE) begin
				if (p_ctx == CTX_KEY)
					k = KIND_KEY;
				else
					k = KIND_UNIT;
				p_ctx = CTX_NONE;
				if (word_b(c)) begin
					open_tok(k);
				end else begin
					put_tok(k, p_off, '0);
					again = 1'b1;
				end
			end else if (word_b(c)) begin
				open_tok(KIND_IDENT);
			end else begin
				put_tok(KIND_STOP, p_off, '0);
				p_halted = 1'b1;
			end
		end
	endfunction

	function automatic void predict_tokens(logic [7:0] c, logic eos);
		logic cont;
		run_toks.delete();
		if (eos) begin
			if (!p_halted) begin
				close_tok();
				if (p_ctx == CTX_VALUE) begin
					put_tok(KIND_VALUE, p_off, '0);
					p_ctx = CTX_UNIT;
				end
				if (p_ctx == CTX_KEY)
					put_tok(KIND_KEY, p_off, '0);
				else if (p_ctx == CTX_UNIT)
					put_tok(KIND_UNIT, p_off, '0);
			end
			put_tok(KIND_STOP, p_off, '0);
			clear_tokenizer();
		end else if (!p_halted) begin
			if (p_open) begin
				cont = (p_kind == KIND_VALUE) ? digit_b(c) : word_b(c);
				if (!cont) begin
					close_tok();
					fresh_byte(c);
				end
			end else begin
				fresh_byte(c);
			end
			if (p_off != '1)
				p_off = p_off + 1'b1;
		end
	endfunction

	task automatic log_mismatch(input string msg);
		n_errors++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// ---- stimulus generation ----

	function automatic void queue_word(logic [7:0] b, logic eos);
		src_word_t w;
		w = '0;
		w.kind = KIND_STOP;
		w.b = b;
		w.eos = eos;
		src_words.insert(src_words.size(), w);
		// bytes swallowed while halted do not count
		if (!gen_halted || eos)
			n_live++;
		if (eos)
			gen_halted = 1'b0;
		else if (!(blank_b(b) || punct_b(b) || word_b(b)))
			gen_halted = 1'b1;
	endfunction

	function automatic logic [7:0] rand_word_char();
		int r;
		r = $urandom_range(0, 63);
		if (r < 26)
			return 8'(8'h61 + r);
		if (r < 52)
			return 8'(8'h41 + r - 26);
		if (r < 62)
			return 8'(8'h30 + r - 52);
		return (r == 62) ? CH_DASH : CH_UNDER;
	endfunction

	function automatic void gen_blanks();
		int r;
		repeat ($urandom_range(0, 2)) begin
			r = $urandom_range(0, 6);
			queue_word((r < 5) ? 8'(CH_TAB + r) : CH_SPACE, 1'b0);
		end
	endfunction

	function automatic void gen_run(int n, logic digits);
		repeat (n)
			queue_word(digits ? 8'(8'h30 + $urandom_range(0, 9)) : rand_word_char(), 1'b0);
	endfunction

	// one rule, mostly well formed; pieces dropped now and then
	function automatic void gen_rule();
		int r;
		int n_decl;
		r = $urandom_range(0, 3);
		if (r == 0)
			queue_word(CH_HASH, 1'b0);
		else if (r == 1)
			queue_word(CH_DOT, 1'b0);
		if ($urandom_range(0, 3) != 0)
			gen_run($urandom_range(1, 8), 1'b0);
		gen_blanks();
		if ($urandom_range(0, 7) != 0)
			queue_word(CH_LBRACE, 1'b0);
		n_decl = $urandom_range(0, 4);
		for (int d = 0; d < n_decl; d++) begin
			gen_blanks();
			if ($urandom_range(0, 5) != 0)
				gen_run($urandom_range(1, 6), 1'b0);
			gen_blanks();
			if ($urandom_range(0, 7) != 0)
				queue_word(CH_COLON, 1'b0);
			gen_blanks();
			if ($urandom_range(0, 4) != 0)
				gen_run($urandom_range(1, 4), 1'b1);
			if ($urandom_range(0, 1) != 0)
				gen_run($urandom_range(1, 3), 1'b0);
			if ($urandom_range(0, 5) != 0)
				queue_word(CH_SEMI, 1'b0);
		end
		gen_blanks();
		if ($urandom_range(0, 5) != 0)
			queue_word(CH_RBRACE, 1'b0);
		if ($urandom_range(0, 11) == 0)
			queue_word(8'($urandom_range(0, 255)), 1'b0);
		if (gen_halted && $urandom_range(0, 2) == 0)
			queue_word(8'($urandom_range(0, 255)), 1'b0);
		if (gen_halted || $urandom_range(0, 4) == 0)
			queue_word(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	function automatic void build_stimulus();
		foreach (directed_tbl[i])
			src_words.insert(src_words.size(), directed_tbl[i]);
		hold_at = src_words.size() + 40;
		n_live = 0;
		while (n_live < RANDOM_WORDS)
			gen_rule();
		queue_word(8'h00, 1'b1);
	endfunction

	// ---- source side ----

	initial begin : drive
		int burst_left;
		int gap;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.source_byte = '0;
		byte_ch.end_of_source = 1'b0;
		clear_tokenizer();
		build_stimulus();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		burst_left = 0;
		for (int i = 0; i < src_words.size(); i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					byte_ch.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
					$urandom_range(1, 20);
			end
			burst_left--;
			if (i == hold_at)
				hold_req = 1'b1;
			byte_ch.valid <= 1'b1;
			byte_ch.source_byte <= src_words[i].b;
			byte_ch.end_of_source <= src_words[i].eos;
			do @(posedge clk); while (!byte_ch.ready);
			@(negedge clk);
		end
		byte_ch.valid <= 1'b0;
		while (pending_toks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_toks.size() != 0)
			log_mismatch($sformatf("%0d tokens never arrived", pending_toks.size()));
		$display("run: %0d source words (%0d directed), %0d tokens checked, %0d stops",
			n_taken, DIRECTED_N, n_tokens, n_stops);
		$display("run: %0d-cycle sink hold %s, %0d mismatches",
			HOLD_CYCLES, hold_done ? "done" : "missed", n_errors);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// ---- sink side ----

	initial begin : receive
		rx_mode_t mode;
		int left;
		logic [15:0] pat;
		tok_ch.ready = 1'b0;
		mode = RX_FREE;
		left = 0;
		pat = 16'hFFFF;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				// long back-pressure: source keeps offering until the block fills
				tok_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(20, 80);
					pat = 16'($urandom());
				end
				left--;
				pat = {pat[0], pat[15:1]};
				case (mode)
					RX_FREE: tok_ch.ready <= 1'b1;
					RX_COIN: tok_ch.ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: tok_ch.ready <= pat[0];
					default: tok_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ---- prediction and checking ----

	always @(posedge clk) begin : check
		src_word_t w;
		tok_exp_t want;
		tok_t got;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				w = src_words[n_taken];
				n_taken++;
				predict_tokens(w.b, w.eos);
				if (w.typed) begin
					want.tok.kind = w.kind;
					want.tok.start = w.start;
					want.tok.length = w.length;
					want.last = 1'b1;
					pending_toks.insert(pending_toks.size(), want);
				end else begin
					foreach (run_toks[i]) begin
						want.tok = run_toks[i];
						want.last = (i == run_toks.size() - 1);
						pending_toks.insert(pending_toks.size(), want);
					end
				end
			end
			if (tok_ch.valid && tok_ch.ready) begin
				got.kind = kind_t'(tok_ch.token_kind);
				got.start = tok_ch.token_start;
				got.length = tok_ch.token_length;
				n_tokens++;
				if (got.kind == KIND_STOP)
					n_stops++;
				if (pending_toks.size() == 0) begin
					log_mismatch($sformatf("token with none pending: kind %0d start %0d len %0d",
						got.kind, got.start, got.length));
				end else begin
					want = pending_toks.pop_front();
					if (got.kind != want.tok.kind || got.start != want.tok.start ||
						got.length != want.tok.length || tok_ch.last_of_run != want.last)
						log_mismatch($sformatf(
							"token %0d: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
							n_tokens, want.tok.kind, want.tok.start, want.tok.length,
							want.last, got.kind, got.start, got.length, tok_ch.last_of_run));
				end
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d tokens pending", CYCLE_LIMIT,
			pending_toks.size());
		$display("simulation failed");
		$finish;
	end

endmodule
